@@ rtl/core/smae_pkg.sv @@
// Shared constants, types and helper functions of the small matrix arithmetic engine.
package smae_pkg;

    localparam int DIM       = 8;
    localparam int FRAC_BITS = 8;
    localparam int CELLS     = DIM * DIM;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Field widths fixed by the interface.
    localparam int IDX_W      = 3;
    localparam int DIMREG_W   = 4;
    localparam int ELEM_W     = 16;
    localparam int VALUE_W    = 32;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = PROD_W + $clog2(DIM) + 1;
    localparam int CONV_W     = ACC_W + 16;

    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Bit positions inside the slave tuser.
    localparam int TUSER_CMD_BIT = 0;
    localparam int TUSER_SEL_BIT = 1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Operation codes.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_TRN  = 3'd3;
    localparam logic [2:0] OP_DIAG = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECTED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_ERR  = 3'b100
    } state_t;

    // A count of zero acts as one, anything above DIM acts as DIM.
    function automatic logic [DIMREG_W-1:0] clamp_dim(input logic [DIMREG_W-1:0] v);
        logic [DIMREG_W-1:0] r;
        if (v == '0)
        begin
            r = DIMREG_W'(1);
        end
        else if (v > DIMREG_W'(DIM))
        begin
            r = DIMREG_W'(DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Row-major entry of element (r, c) in a matrix with ncols columns.
    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c,
                                                    input logic [DIMREG_W-1:0] ncols);
        logic [IDX_W+DIMREG_W:0] t;
        t = (IDX_W+DIMREG_W+1)'(r) * (IDX_W+DIMREG_W+1)'(ncols)
            + (IDX_W+DIMREG_W+1)'(c);
        return t[ADDR_W-1:0];
    endfunction

    // Converts a value with fb fraction bits to saturated Q16.16. The right
    // shift is arithmetic, so it rounds toward minus infinity.
    function automatic logic signed [VALUE_W-1:0] to_q16(input logic signed [ACC_W-1:0] v,
                                                         input int fb);
        logic signed [CONV_W-1:0] w;
        logic signed [CONV_W-1:0] r;
        logic signed [VALUE_W-1:0] q;
        w = CONV_W'(v);
        if (fb <= 16)
        begin
            r = w <<< (16 - fb);
        end
        else
        begin
            r = w >>> (fb - 16);
        end
        if (r[CONV_W-1:VALUE_W-1] == '0 || r[CONV_W-1:VALUE_W-1] == '1)
        begin
            q = r[VALUE_W-1:0];
        end
        else if (r[CONV_W-1])
        begin
            q = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            q = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return q;
    endfunction

endpackage

@@ rtl/core/smae_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module smae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/small_matrix_arith_engine.sv @@
// Top level of the small matrix arithmetic engine.
//
// Elements of two matrices of up to 8 by 8 signed Q8.8 values are loaded in
// row-major order, one per transfer on the slave stream (tuser bit 0 low, tuser
// bit 1 picks the matrix); each matrix has its own wrapping load position.
// A transfer with tuser bit 0 high runs the configured operation on the
// current dimensions and streams the result in row-major order as saturated
// Q16.16, tlast on the final element; an invalid shape gives a single result
// with tuser set. The two element stores are single-port-read memories, so a
// run issues one read per cycle while the output is not stalled: rows*cols
// reads for add, subtract and transpose, rows for the diagonal, and
// rows_a*cols_b*cols_a reads for multiply (one multiply-accumulate per read).
// The next transfer is taken only once the read and accumulate stages have
// drained. Output back-pressure stalls the whole pipeline.
module small_matrix_arith_engine
    import smae_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [15:0] elem_value
    input  logic [S_TUSER_W-1:0]   s_tuser,   // [0] command, [1] matrix_sel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [2:0] out_row, [5:3] out_col,
                                              // [37:6] out_value, [39:38] zero
    output logic                   m_tlast,   // last
    output logic [M_TUSER_W-1:0]   m_tuser,   // [0] error
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [2:0]           op_reg;
    logic                 sel_reg;
    logic [DIMREG_W-1:0]  rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [ADDR_W-1:0]    pos_a_reg, pos_b_reg;

    logic [IDX_W-1:0]     ci_reg, cj_reg, ck_reg;
    logic [DIMREG_W-1:0]  lim_i_reg, lim_j_reg, lim_k_reg;

    logic                 p1_valid_reg, p1_first_reg, p1_last_k_reg, p1_last_reg;
    logic [IDX_W-1:0]     p1_row_reg, p1_col_reg;

    logic                 s2_valid_reg, s2_last_reg;
    logic [IDX_W-1:0]     s2_row_reg, s2_col_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic                 out_valid_reg, out_last_reg, out_err_reg;
    logic [IDX_W-1:0]     out_row_reg, out_col_reg;
    logic signed [VALUE_W-1:0] out_value_reg;

    logic [DIMREG_W-1:0]  ra, ca, rb, cb, n_rows, n_cols;
    logic                 advance, in_fire, run_fire, load_fire, issue;
    logic                 last_i, last_j, last_k, run_err;
    logic [ADDR_W-1:0]    addr_a, addr_b;
    logic [ELEM_W-1:0]    rdata_a, rdata_b;
    logic signed [ELEM_W-1:0] a_val, b_val;
    logic signed [PROD_W-1:0] prod;

    assign ra     = clamp_dim(rows_a_reg);
    assign ca     = clamp_dim(cols_a_reg);
    assign rb     = clamp_dim(rows_b_reg);
    assign cb     = clamp_dim(cols_b_reg);
    assign n_rows = sel_reg ? rb : ra;
    assign n_cols = sel_reg ? cb : ca;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !p1_valid_reg && !s2_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign run_fire  = in_fire && (s_tuser[TUSER_CMD_BIT] == CMD_RUN);
    assign load_fire = in_fire && (s_tuser[TUSER_CMD_BIT] == CMD_LOAD);
    assign issue     = (state_reg == ST_RUN) && advance;
    assign cfg_ready = 1'b1;

    assign last_i = ci_reg == IDX_W'(lim_i_reg - DIMREG_W'(1));
    assign last_j = cj_reg == IDX_W'(lim_j_reg - DIMREG_W'(1));
    assign last_k = ck_reg == IDX_W'(lim_k_reg - DIMREG_W'(1));

    always_comb
    begin
        case (op_reg)
            OP_ADD, OP_SUB: run_err = (ra != rb) || (ca != cb);
            OP_MUL:         run_err = ca != rb;
            OP_TRN:         run_err = 1'b0;
            OP_DIAG:        run_err = n_rows != n_cols;
            default:        run_err = 1'b1;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                addr_a = elem_addr(ci_reg, cj_reg, ca);
                addr_b = elem_addr(ci_reg, cj_reg, cb);
            end
            OP_MUL:
            begin
                addr_a = elem_addr(ci_reg, ck_reg, ca);
                addr_b = elem_addr(ck_reg, cj_reg, cb);
            end
            OP_TRN:
            begin
                addr_a = elem_addr(cj_reg, ci_reg, n_cols);
                addr_b = addr_a;
            end
            OP_DIAG:
            begin
                addr_a = elem_addr(ci_reg, ci_reg, n_cols);
                addr_b = addr_a;
            end
            default:
            begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    smae_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_a (
        .clk   (clk),
        .we    (load_fire && !s_tuser[TUSER_SEL_BIT]),
        .waddr (pos_a_reg),
        .wdata (s_tdata[ELEM_W-1:0]),
        .re    (issue),
        .raddr (addr_a),
        .rdata (rdata_a)
    );

    smae_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_b (
        .clk   (clk),
        .we    (load_fire && s_tuser[TUSER_SEL_BIT]),
        .waddr (pos_b_reg),
        .wdata (s_tdata[ELEM_W-1:0]),
        .re    (issue),
        .raddr (addr_b),
        .rdata (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (run_fire)
                begin
                    state_next = run_err ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue && last_i && last_j && last_k)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Configuration, load positions, sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_ADD;
            sel_reg       <= 1'b0;
            rows_a_reg    <= DIMREG_W'(1);
            cols_a_reg    <= DIMREG_W'(1);
            rows_b_reg    <= DIMREG_W'(1);
            cols_b_reg    <= DIMREG_W'(1);
            pos_a_reg     <= '0;
            pos_b_reg     <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            lim_i_reg     <= DIMREG_W'(1);
            lim_j_reg     <= DIMREG_W'(1);
            lim_k_reg     <= DIMREG_W'(1);
            p1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OPERATION: op_reg     <= 3'(cfg_data);
                    REG_SELECTED:  sel_reg    <= cfg_data[0];
                    REG_ROWS_A:    rows_a_reg <= cfg_data;
                    REG_COLS_A:    cols_a_reg <= cfg_data;
                    REG_ROWS_B:    rows_b_reg <= cfg_data;
                    REG_COLS_B:    cols_b_reg <= cfg_data;
                    default:       ;
                endcase
            end

            if (load_fire)
            begin
                if (s_tuser[TUSER_SEL_BIT])
                begin
                    pos_b_reg <= (pos_b_reg == ADDR_W'(CELLS - 1)) ? '0 : pos_b_reg + 1'b1;
                end
                else
                begin
                    pos_a_reg <= (pos_a_reg == ADDR_W'(CELLS - 1)) ? '0 : pos_a_reg + 1'b1;
                end
            end

            if (run_fire)
            begin
                ci_reg <= '0;
                cj_reg <= '0;
                ck_reg <= '0;
                case (op_reg)
                    OP_MUL:
                    begin
                        lim_i_reg <= ra;
                        lim_j_reg <= cb;
                        lim_k_reg <= ca;
                    end
                    OP_TRN:
                    begin
                        lim_i_reg <= n_cols;
                        lim_j_reg <= n_rows;
                        lim_k_reg <= DIMREG_W'(1);
                    end
                    OP_DIAG:
                    begin
                        lim_i_reg <= n_rows;
                        lim_j_reg <= DIMREG_W'(1);
                        lim_k_reg <= DIMREG_W'(1);
                    end
                    default:
                    begin
                        lim_i_reg <= ra;
                        lim_j_reg <= ca;
                        lim_k_reg <= DIMREG_W'(1);
                    end
                endcase
            end
            else if (issue)
            begin
                if (!last_k)
                begin
                    ck_reg <= ck_reg + 1'b1;
                end
                else
                begin
                    ck_reg <= '0;
                    if (!last_j)
                    begin
                        cj_reg <= cj_reg + 1'b1;
                    end
                    else
                    begin
                        cj_reg <= '0;
                        ci_reg <= ci_reg + 1'b1;
                    end
                end
            end

            if (advance)
            begin
                p1_valid_reg  <= issue;
                s2_valid_reg  <= p1_valid_reg && (op_reg != OP_MUL || p1_last_k_reg);
                out_valid_reg <= (state_reg == ST_ERR) || s2_valid_reg;
            end
        end
    end

    assign a_val = rdata_a;
    assign b_val = rdata_b;
    assign prod  = a_val * b_val;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  acc_next = ACC_W'(a_val) + ACC_W'(b_val);
            OP_SUB:  acc_next = ACC_W'(a_val) - ACC_W'(b_val);
            OP_MUL:  acc_next = (p1_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod);
            default: acc_next = sel_reg ? ACC_W'(b_val) : ACC_W'(a_val);
        endcase
    end

    // Pipeline payload: read tags, accumulator and output register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (issue)
            begin
                p1_row_reg    <= ci_reg;
                p1_col_reg    <= (op_reg == OP_DIAG) ? ci_reg : cj_reg;
                p1_first_reg  <= ck_reg == '0;
                p1_last_k_reg <= last_k;
                p1_last_reg   <= last_i && last_j && last_k;
            end
            if (p1_valid_reg)
            begin
                acc_reg     <= acc_next;
                s2_row_reg  <= p1_row_reg;
                s2_col_reg  <= p1_col_reg;
                s2_last_reg <= p1_last_reg;
            end
            if (state_reg == ST_ERR)
            begin
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_value_reg <= '0;
                out_last_reg  <= 1'b1;
                out_err_reg   <= 1'b1;
            end
            else if (s2_valid_reg)
            begin
                out_row_reg   <= s2_row_reg;
                out_col_reg   <= s2_col_reg;
                out_value_reg <= (op_reg == OP_MUL) ? to_q16(acc_reg, 2 * FRAC_BITS)
                                                    : to_q16(acc_reg, FRAC_BITS);
                out_last_reg  <= s2_last_reg;
                out_err_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - VALUE_W - 2 * IDX_W)'(0), out_value_reg,
                       out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

@@ rtl/core/smae_checker.sv @@
// Port-level assertions for the small matrix arithmetic engine, bound to the top level.
module smae_checker
    import smae_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_TUSER_W-1:0]   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata,
    input logic                   m_tlast,
    input logic [M_TUSER_W-1:0]   m_tuser
);

    // A stalled result transfer keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // An error result is alone in its run and carries zero data.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0)
        else $error("malformed error result");

    // Once a run is taken, no further input transfer is taken in the next cycle.
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[TUSER_CMD_BIT] == CMD_RUN |=> !s_tready)
        else $error("input taken right after a run");

    // Load transfers never produce results by themselves.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && s_tready |=> !m_tvalid)
        else $error("result appeared while idle");

endmodule

bind small_matrix_arith_engine smae_checker u_smae_checker (.*);
